@@ rtl/adpcm_block_decoder_unit_assert.svh @@
// Assertion macros for the ADPCM block decoder.
// Macro bodies expect clk_i and rst_ni to be visible in the including scope.
`ifndef ADPCM_BLOCK_DECODER_UNIT_ASSERT_SVH
`define ADPCM_BLOCK_DECODER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define ABD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ABD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ABD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/abd_pkg.sv @@
// Shared types, constants and decode tables for the ADPCM block decoder.
// No dependencies; the controller, datapath and top level refer to this package by scoped names.
package abd_pkg;

  // Header lengths in bytes and limits
  localparam logic [2:0] HDR_LEN_IMA = 3'd4;
  localparam logic [2:0] HDR_LEN_MS  = 3'd7;
  localparam logic [2:0] HDR_STORE   = 3'd6;   // header bytes kept in the header store
  localparam logic [6:0] IMA_STEP_MAX = 7'd88;
  localparam logic [2:0] COEFF_MAX    = 3'd6;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [15:0] DELTA_MIN  = 16'sd16;
  localparam logic signed [15:0] DELTA_MAX  = 16'sh7FFF;

  // IMA step size table, index 0..88
  localparam logic [14:0] IMA_STEPS [89] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_HDR_EMIT0,
    ST_HDR_EMIT1,
    ST_IMA_NIB,
    ST_MS_MUL1,
    ST_MS_MUL2,
    ST_MS_MUL3,
    ST_MS_MUL4,
    ST_MS_DELTA,
    ST_NIB_EMIT
  } abd_state_e;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MUL_S1C1,
    MUL_S2C2,
    MUL_CODE,
    MUL_ADAPT
  } abd_mul_e;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } abd_acc_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     hdr_step;
    logic     hdr_load;
    logic     ima_step;
    logic     mul_en;
    abd_mul_e mul_op;
    abd_acc_e acc_op;
    logic     ms_pred;
    logic     ms_delta;
    logic     nib_clear;
    logic     nib_next;
    logic     out_load;
    logic     out_older;
    logic     out_last;
  } abd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       ms;
    logic       hdr_phase;
    logic       hdr_done;
    logic       nib_second;
    logic [6:0] step_pos;
    logic [2:0] coeff_sel;
  } abd_stat_t;

  function automatic logic [14:0] ima_step_size(input logic [6:0] idx);
    logic [6:0] i;
    i = (idx > IMA_STEP_MAX) ? IMA_STEP_MAX : idx;
    return IMA_STEPS[i];
  endfunction

  function automatic logic signed [7:0] ima_index_adj(input logic [2:0] mag);
    case (mag)
      3'd4:    return 8'sd2;
      3'd5:    return 8'sd4;
      3'd6:    return 8'sd6;
      3'd7:    return 8'sd8;
      default: return -8'sd1;
    endcase
  endfunction

  function automatic logic [9:0] ms_adapt(input logic [3:0] nib);
    case (nib)
      4'd4, 4'd12: return 10'd307;
      4'd5, 4'd11: return 10'd409;
      4'd6, 4'd10: return 10'd512;
      4'd7, 4'd9:  return 10'd614;
      4'd8:        return 10'd768;
      default:     return 10'd230;
    endcase
  endfunction

  // First coefficient of each pair; codes above the last pair use the last pair
  function automatic logic signed [11:0] ms_coef1(input logic [2:0] sel);
    case (sel)
      3'd0:    return 12'sd256;
      3'd1:    return 12'sd512;
      3'd2:    return 12'sd0;
      3'd3:    return 12'sd192;
      3'd4:    return 12'sd240;
      3'd5:    return 12'sd460;
      default: return 12'sd392;
    endcase
  endfunction

  function automatic logic signed [11:0] ms_coef2(input logic [2:0] sel);
    case (sel)
      3'd0:    return 12'sd0;
      3'd1:    return -12'sd256;
      3'd2:    return 12'sd0;
      3'd3:    return 12'sd64;
      3'd4:    return 12'sd0;
      3'd5:    return -12'sd208;
      default: return -12'sd232;
    endcase
  endfunction

endpackage

@@ rtl/abd_in_if.sv @@
// Input byte channel of the ADPCM block decoder: valid/ready plus one block byte.
// No dependencies.
interface abd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

@@ rtl/abd_out_if.sv @@
// Output sample channel of the ADPCM block decoder: valid/ready plus one PCM sample.
// No dependencies.
interface abd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               run_last;

  modport source (output valid, output pcm_sample, output run_last, input ready);
  modport sink   (input valid, input pcm_sample, input run_last, output ready);
endinterface

@@ rtl/abd_ctrl.sv @@
// Sequencing controller of the ADPCM block decoder: steps one input beat
// through header or nibble decode and drives the output valid. Uses abd_pkg.
module abd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  abd_pkg::abd_stat_t stat_i,
  output abd_pkg::abd_cmd_t  cmd_o
);

  abd_pkg::abd_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  // Output register can take a new beat when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_op = abd_pkg::MUL_S1C1;
    cmd_o.acc_op = abd_pkg::ACC_HOLD;

    case (state_q)
      abd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = abd_pkg::ST_DECODE;
        end
      end

      abd_pkg::ST_DECODE: begin
        if (stat_i.hdr_phase) begin
          cmd_o.hdr_step = 1'b1;
          if (stat_i.hdr_done) begin
            cmd_o.hdr_load = 1'b1;
            state_d = stat_i.ms ? abd_pkg::ST_HDR_EMIT0 : abd_pkg::ST_HDR_EMIT1;
          end else begin
            state_d = abd_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.nib_clear = 1'b1;
          state_d = stat_i.ms ? abd_pkg::ST_MS_MUL1 : abd_pkg::ST_IMA_NIB;
        end
      end

      // MS header: older sample first
      abd_pkg::ST_HDR_EMIT0: begin
        if (out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_older = 1'b1;
          state_d         = abd_pkg::ST_HDR_EMIT1;
        end
      end

      abd_pkg::ST_HDR_EMIT1: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = abd_pkg::ST_IDLE;
        end
      end

      abd_pkg::ST_IMA_NIB: begin
        cmd_o.ima_step = 1'b1;
        state_d        = abd_pkg::ST_NIB_EMIT;
      end

      // MS predictor: s1*c1, s2*c2, code*delta, then adapt*delta
      abd_pkg::ST_MS_MUL1: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = abd_pkg::MUL_S1C1;
        state_d      = abd_pkg::ST_MS_MUL2;
      end

      abd_pkg::ST_MS_MUL2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = abd_pkg::MUL_S2C2;
        cmd_o.acc_op = abd_pkg::ACC_LOAD;
        state_d      = abd_pkg::ST_MS_MUL3;
      end

      abd_pkg::ST_MS_MUL3: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = abd_pkg::MUL_CODE;
        cmd_o.acc_op = abd_pkg::ACC_ADD;
        state_d      = abd_pkg::ST_MS_MUL4;
      end

      abd_pkg::ST_MS_MUL4: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_op  = abd_pkg::MUL_ADAPT;
        cmd_o.ms_pred = 1'b1;
        state_d       = abd_pkg::ST_MS_DELTA;
      end

      abd_pkg::ST_MS_DELTA: begin
        cmd_o.ms_delta = 1'b1;
        state_d        = abd_pkg::ST_NIB_EMIT;
      end

      abd_pkg::ST_NIB_EMIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = stat_i.nib_second;
          if (stat_i.nib_second) begin
            state_d = abd_pkg::ST_IDLE;
          end else begin
            cmd_o.nib_next = 1'b1;
            state_d = stat_i.ms ? abd_pkg::ST_MS_MUL1 : abd_pkg::ST_IMA_NIB;
          end
        end
      end

      default: begin
        state_d = abd_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the beat is taken
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/abd_datapath.sv @@
// Datapath of the ADPCM block decoder: header store, decoder state, IMA step
// logic, shared multiplier with accumulator, output register. Uses abd_pkg.
module abd_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic [7:0]         data_byte_i,
  input  logic               block_start_i,
  input  abd_pkg::abd_cmd_t  cmd_i,
  output abd_pkg::abd_stat_t stat_o,
  output logic signed [15:0] pcm_sample_o,
  output logic               run_last_o
);

  // Configuration and decoder state
  logic               fmt_q;
  logic [7:0]         byte_q;
  logic               start_q;
  logic [2:0]         pos_q;
  logic [47:0]        hdr_q;
  logic signed [15:0] newest_q, newest_d;
  logic signed [15:0] older_q, older_d;
  logic [6:0]         step_q, step_d;
  logic signed [15:0] delta_q, delta_d;
  logic [2:0]         coeff_q, coeff_d;
  logic               nib_q;

  // Multiplier and accumulator
  logic signed [33:0] prod_q;
  logic signed [28:0] acc_q;
  logic signed [16:0] mul_a, mul_b;

  // Output register payload
  logic signed [15:0] out_sample_q;
  logic               out_last_q;

  // Header position bookkeeping
  logic [2:0] pos_eff;
  logic [2:0] hdr_len;
  logic [3:0] pos_inc;
  logic [3:0] nib;

  assign pos_eff = start_q ? 3'd0 : pos_q;
  assign hdr_len = fmt_q ? abd_pkg::HDR_LEN_MS : abd_pkg::HDR_LEN_IMA;
  assign pos_inc = {1'b0, pos_eff} + 4'd1;

  // Current nibble: IMA low nibble first, MS high nibble first
  always_comb begin
    if (fmt_q) begin
      nib = nib_q ? byte_q[3:0] : byte_q[7:4];
    end else begin
      nib = nib_q ? byte_q[7:4] : byte_q[3:0];
    end
  end

  // Status to the controller
  always_comb begin
    stat_o.ms         = fmt_q;
    stat_o.hdr_phase  = pos_eff < hdr_len;
    stat_o.hdr_done   = pos_inc == {1'b0, hdr_len};
    stat_o.nib_second = nib_q;
    stat_o.step_pos   = step_q;
    stat_o.coeff_sel  = coeff_q;
  end

  // IMA nibble decode
  logic [6:0]         step_idx;
  logic [14:0]        step_sz;
  logic [15:0]        ima_diff;
  logic signed [17:0] ima_diff_s;
  logic signed [17:0] ima_sum;
  logic signed [15:0] ima_sample;
  logic signed [7:0]  idx_sum;
  logic [6:0]         idx_next;

  always_comb begin
    step_idx = (step_q > abd_pkg::IMA_STEP_MAX) ? abd_pkg::IMA_STEP_MAX : step_q;
    step_sz  = abd_pkg::ima_step_size(step_idx);
    ima_diff = {4'b0, step_sz[14:3]}
             + (nib[0] ? {3'b0, step_sz[14:2]} : 16'd0)
             + (nib[1] ? {2'b0, step_sz[14:1]} : 16'd0)
             + (nib[2] ? {1'b0, step_sz}       : 16'd0);
    ima_diff_s = $signed({2'b00, ima_diff});
    ima_sum = {{2{newest_q[15]}}, newest_q} + (nib[3] ? -ima_diff_s : ima_diff_s);
    if (ima_sum > 18'(abd_pkg::SAMPLE_MAX)) begin
      ima_sample = abd_pkg::SAMPLE_MAX;
    end else if (ima_sum < 18'(abd_pkg::SAMPLE_MIN)) begin
      ima_sample = abd_pkg::SAMPLE_MIN;
    end else begin
      ima_sample = ima_sum[15:0];
    end
    idx_sum = $signed({1'b0, step_idx}) + abd_pkg::ima_index_adj(nib[2:0]);
    if (idx_sum < 8'sd0) begin
      idx_next = 7'd0;
    end else if (idx_sum > $signed({1'b0, abd_pkg::IMA_STEP_MAX})) begin
      idx_next = abd_pkg::IMA_STEP_MAX;
    end else begin
      idx_next = idx_sum[6:0];
    end
  end

  // Multiplier operand select
  always_comb begin
    case (cmd_i.mul_op)
      abd_pkg::MUL_S1C1: begin
        mul_a = {newest_q[15], newest_q};
        mul_b = 17'(abd_pkg::ms_coef1(coeff_q));
      end
      abd_pkg::MUL_S2C2: begin
        mul_a = {older_q[15], older_q};
        mul_b = 17'(abd_pkg::ms_coef2(coeff_q));
      end
      abd_pkg::MUL_CODE: begin
        mul_a = {{13{nib[3]}}, nib};
        mul_b = {delta_q[15], delta_q};
      end
      abd_pkg::MUL_ADAPT: begin
        mul_a = {7'b0, abd_pkg::ms_adapt(nib)};
        mul_b = {delta_q[15], delta_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // MS prediction and delta adaptation
  logic signed [21:0] pred_sum;
  logic signed [15:0] ms_sample;
  logic signed [18:0] delta_raw;
  logic signed [15:0] delta_new;

  always_comb begin
    pred_sum = $signed({acc_q[28], acc_q[28:8]}) + $signed(prod_q[21:0]);
    if (pred_sum > 22'(abd_pkg::SAMPLE_MAX)) begin
      ms_sample = abd_pkg::SAMPLE_MAX;
    end else if (pred_sum < 22'(abd_pkg::SAMPLE_MIN)) begin
      ms_sample = abd_pkg::SAMPLE_MIN;
    end else begin
      ms_sample = pred_sum[15:0];
    end
    delta_raw = $signed(prod_q[26:8]);
    if (delta_raw < 19'(abd_pkg::DELTA_MIN)) begin
      delta_new = abd_pkg::DELTA_MIN;
    end else if (delta_raw > 19'(abd_pkg::DELTA_MAX)) begin
      delta_new = abd_pkg::DELTA_MAX;
    end else begin
      delta_new = delta_raw[15:0];
    end
  end

  // Next decoder state
  always_comb begin
    newest_d = newest_q;
    older_d  = older_q;
    step_d   = step_q;
    delta_d  = delta_q;
    coeff_d  = coeff_q;
    if (cmd_i.hdr_load) begin
      if (fmt_q) begin
        coeff_d  = (hdr_q[7:0] > {5'b0, abd_pkg::COEFF_MAX}) ? abd_pkg::COEFF_MAX
                                                             : hdr_q[2:0];
        delta_d  = $signed(hdr_q[23:8]);
        newest_d = $signed(hdr_q[39:24]);
        older_d  = $signed({byte_q, hdr_q[47:40]});
      end else begin
        newest_d = $signed(hdr_q[15:0]);
        step_d   = (hdr_q[23:16] > {1'b0, abd_pkg::IMA_STEP_MAX}) ? abd_pkg::IMA_STEP_MAX
                                                                  : hdr_q[22:16];
      end
    end
    if (cmd_i.ima_step) begin
      newest_d = ima_sample;
      step_d   = idx_next;
    end
    if (cmd_i.ms_pred) begin
      older_d  = newest_q;
      newest_d = ms_sample;
    end
    if (cmd_i.ms_delta) begin
      delta_d = delta_new;
    end
  end

  // Decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= 1'b0;
      pos_q    <= 3'd0;
      hdr_q    <= '0;
      newest_q <= '0;
      older_q  <= '0;
      step_q   <= '0;
      delta_q  <= '0;
      coeff_q  <= '0;
      nib_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      if (cmd_i.hdr_step) begin
        pos_q <= pos_inc[2:0];
        for (int k = 0; k < int'(abd_pkg::HDR_STORE); k++) begin
          if (pos_eff == 3'(k)) begin
            hdr_q[8*k +: 8] <= byte_q;
          end
        end
      end
      newest_q <= newest_d;
      older_q  <= older_d;
      step_q   <= step_d;
      delta_q  <= delta_d;
      coeff_q  <= coeff_d;
      if (cmd_i.nib_clear) begin
        nib_q <= 1'b0;
      end else if (cmd_i.nib_next) begin
        nib_q <= 1'b1;
      end
    end
  end

  // Input capture, multiplier, accumulator and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q  <= data_byte_i;
      start_q <= block_start_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (cmd_i.acc_op)
      abd_pkg::ACC_LOAD: acc_q <= prod_q[28:0];
      abd_pkg::ACC_ADD:  acc_q <= acc_q + prod_q[28:0];
      default:           acc_q <= acc_q;
    endcase
    if (cmd_i.out_load) begin
      out_sample_q <= cmd_i.out_older ? older_q : newest_q;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign pcm_sample_o = out_sample_q;
  assign run_last_o   = out_last_q;

endmodule

@@ rtl/adpcm_block_decoder_unit.sv @@
// ADPCM block decoder top level: abd_ctrl sequencer plus abd_datapath, uses abd_pkg.
// One byte at a time; header bytes are stored, and a completing header emits its samples.
// IMA data byte: a step state and an output state per nibble.
// MS data byte: four passes through the one shared multiplier per nibble, then a delta update.
// Output waits stall. Asynchronous active-low reset clears control and decoder state, format IMA.
`include "adpcm_block_decoder_unit_assert.svh"

module adpcm_block_decoder_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  abd_in_if.sink    in_i,
  abd_out_if.source out_o
);

  abd_pkg::abd_cmd_t  cmd;
  abd_pkg::abd_stat_t stat;
  logic               out_valid;

  // Sequencer
  abd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath
  abd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .data_byte_i   (in_i.data_byte),
    .block_start_i (in_i.block_start),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pcm_sample_o  (out_o.pcm_sample),
    .run_last_o    (out_o.run_last)
  );

  assign out_o.valid = out_valid;

  // Checks
  `ABD_ASSERT_NEXT(a_one_beat_at_a_time, in_i.valid && in_i.ready, !in_i.ready, "input taken while busy")
  `ABD_ASSERT_ALWAYS(a_step_in_range, stat.step_pos <= abd_pkg::IMA_STEP_MAX, "IMA step index out of range")
  `ABD_ASSERT_ALWAYS(a_coeff_in_range, stat.coeff_sel <= abd_pkg::COEFF_MAX, "MS coefficient index out of range")
  `ABD_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_o.valid || out_o.ready, "output beat overwritten")

endmodule
